// ----- design/vwfd_pkg.sv -----
// Shared types, constants and a helper function for the voltage window fault debouncer.
// No dependencies; the classifier, side and top-level design files import this package.
package vwfd_pkg;

  localparam int unsigned MvWidth   = 16;
  localparam int unsigned TickWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Register reset values (thresholds assume a 10 ms tick).
  localparam logic [MvWidth-1:0]   HighUpperReset = 16'd17000;
  localparam logic [MvWidth-1:0]   HighLowerReset = 16'd16000;
  localparam logic [MvWidth-1:0]   LowLowerReset  = 16'd8000;
  localparam logic [MvWidth-1:0]   LowUpperReset  = 16'd9000;
  localparam logic [TickWidth-1:0] DetectReset    = 16'd1000;
  localparam logic [TickWidth-1:0] RecoverReset   = 16'd400;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_HIGH_UPPER    = 3'd0,
    CFG_HIGH_LOWER    = 3'd1,
    CFG_LOW_LOWER     = 3'd2,
    CFG_LOW_UPPER     = 3'd3,
    CFG_DETECT_TICKS  = 3'd4,
    CFG_RECOVER_TICKS = 3'd5
  } cfg_idx_e;

  // Window limits seen by the classifier.
  typedef struct packed {
    logic [MvWidth-1:0] ov_trip;
    logic [MvWidth-1:0] ov_release;
    logic [MvWidth-1:0] uv_trip;
    logic [MvWidth-1:0] uv_release;
  } vwfd_limits_t;

  // Per-tick control for one debounce side.
  typedef struct packed {
    logic step;         // an item is processed this cycle
    logic clear;        // clear counters and flag
    logic detect_mode;  // sample is out of window on this side
    logic precond;      // detection precondition holds
    logic force_clear;  // force the flag clear
  } vwfd_side_ctrl_t;

  // Saturating increment: min(count + 1, limit).
  function automatic logic [TickWidth-1:0] sat_inc(logic [TickWidth-1:0] count,
                                                   logic [TickWidth-1:0] limit);
    logic [TickWidth:0] nxt;
    nxt = {1'b0, count} + {{TickWidth{1'b0}}, 1'b1};
    return (nxt < {1'b0, limit}) ? nxt[TickWidth-1:0] : limit;
  endfunction

endpackage

// ----- design/vwfd_classify.sv -----
// Window classifier: decides whether a sample is high, low or in window.
// Depends on vwfd_pkg for the limit struct.
module vwfd_classify import vwfd_pkg::*; (
  input  logic [MvWidth-1:0] voltage_mv_i,
  input  vwfd_limits_t       limits_i,
  input  logic               high_fault_i,
  input  logic               low_fault_i,
  output logic               is_high_o,
  output logic               is_low_o
);

  logic above_upper, above_lower, below_lower, below_upper;

  // Hysteresis compares; the high test has priority over the low one.
  always_comb begin
    above_upper = voltage_mv_i > limits_i.ov_trip;
    above_lower = voltage_mv_i > limits_i.ov_release;
    below_lower = voltage_mv_i < limits_i.uv_trip;
    below_upper = voltage_mv_i < limits_i.uv_release;
    is_high_o   = above_upper || (above_lower && high_fault_i);
    is_low_o    = !is_high_o && (below_lower || (below_upper && low_fault_i));
  end

endmodule

// ----- design/vwfd_side.sv -----
// One debounce side: detect and recover tick counters plus the fault flag.
// Depends on vwfd_pkg for the control struct and the saturating increment.
module vwfd_side import vwfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vwfd_side_ctrl_t      ctrl_i,
  input  logic [TickWidth-1:0] detect_ticks_i,
  input  logic [TickWidth-1:0] recover_ticks_i,
  output logic                 fault_o,
  output logic                 fault_next_o
);

  logic [TickWidth-1:0] detect_q, detect_d;
  logic [TickWidth-1:0] recover_q, recover_d;
  logic                 fault_q, fault_d;
  logic [TickWidth-1:0] detect_base;
  logic [TickWidth-1:0] step_detect, step_recover;
  logic                 step_fault;

  // Counter and flag update for one tick.
  always_comb begin
    // Without the precondition a detect count only survives while the fault is set.
    detect_base = (!ctrl_i.precond && !fault_q) ? '0 : detect_q;

    if (ctrl_i.detect_mode) begin
      if (ctrl_i.precond) begin
        step_detect  = sat_inc(detect_base, detect_ticks_i);
        step_recover = '0;
      end else begin
        step_detect  = detect_base;
        step_recover = recover_q;
      end
    end else begin
      step_detect  = '0;
      step_recover = sat_inc(recover_q, recover_ticks_i);
    end

    // Detect sets, recover then clears, a forced clear wins over both.
    step_fault = fault_q;
    if (step_detect == detect_ticks_i) begin
      step_fault = 1'b1;
    end
    if (step_recover == recover_ticks_i) begin
      step_fault = 1'b0;
    end
    if (ctrl_i.force_clear) begin
      step_fault = 1'b0;
    end

    priority if (ctrl_i.step && ctrl_i.clear) begin
      detect_d  = '0;
      recover_d = '0;
      fault_d   = 1'b0;
    end else if (ctrl_i.step) begin
      detect_d  = step_detect;
      recover_d = step_recover;
      fault_d   = step_fault;
    end else begin
      detect_d  = detect_q;
      recover_d = recover_q;
      fault_d   = fault_q;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q  <= '0;
      recover_q <= '0;
      fault_q   <= 1'b0;
    end else begin
      detect_q  <= detect_d;
      recover_q <= recover_d;
      fault_q   <= fault_d;
    end
  end

  assign fault_o      = fault_q;
  assign fault_next_o = fault_d;

endmodule

// ----- design/voltage_window_fault_debouncer_top.sv -----
// Flow: each accepted item enters the input register and moves on to the result
// register once the result register is free or drains.
// Throughput: one item per cycle, unless the result stalls; each item is processed
// in a single pass between input and result registers, with the fault state fed back.
// Reset: asynchronous, active low; clears counters, flags and valids and loads
// the register defaults. Depends on vwfd_pkg, vwfd_classify and vwfd_side.
module voltage_window_fault_debouncer_top import vwfd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  // Input item channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [MvWidth-1:0]      voltage_mv_i,
  input  logic                    precond_ok_i,
  input  logic                    force_clear_high_i,
  input  logic                    force_clear_low_i,
  input  logic                    clear_all_i,
  // Result item channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    high_fault_o,
  output logic                    low_fault_o
);

  vwfd_limits_t         limits_q;
  logic [TickWidth-1:0] detect_ticks_q, recover_ticks_q;

  logic                 in_valid_q;
  logic [MvWidth-1:0]   voltage_q;
  logic                 precond_q, fc_high_q, fc_low_q, clear_q;

  logic                 out_valid_q;
  logic                 high_fault_q, low_fault_q;

  logic                 in_accept, advance;
  logic                 is_high, is_low;
  logic                 high_fault_cur, low_fault_cur;
  logic                 high_fault_next, low_fault_next;
  vwfd_side_ctrl_t      high_ctrl, low_ctrl;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.ov_trip    <= HighUpperReset;
      limits_q.ov_release <= HighLowerReset;
      limits_q.uv_trip    <= LowLowerReset;
      limits_q.uv_release <= LowUpperReset;
      detect_ticks_q      <= DetectReset;
      recover_ticks_q     <= RecoverReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HIGH_UPPER:    limits_q.ov_trip    <= cfg_data_i;
        CFG_HIGH_LOWER:    limits_q.ov_release <= cfg_data_i;
        CFG_LOW_LOWER:     limits_q.uv_trip    <= cfg_data_i;
        CFG_LOW_UPPER:     limits_q.uv_release <= cfg_data_i;
        CFG_DETECT_TICKS:  detect_ticks_q      <= cfg_data_i;
        CFG_RECOVER_TICKS: recover_ticks_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the held item moves on whenever the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      voltage_q <= voltage_mv_i;
      precond_q <= precond_ok_i;
      fc_high_q <= force_clear_high_i;
      fc_low_q  <= force_clear_low_i;
      clear_q   <= clear_all_i;
    end
  end

  // Window classification against the flags from before this item.
  vwfd_classify u_classify (
    .voltage_mv_i (voltage_q),
    .limits_i     (limits_q),
    .high_fault_i (high_fault_cur),
    .low_fault_i  (low_fault_cur),
    .is_high_o    (is_high),
    .is_low_o     (is_low)
  );

  // Side controls.
  always_comb begin
    high_ctrl.step        = advance;
    high_ctrl.clear       = clear_q;
    high_ctrl.detect_mode = is_high;
    high_ctrl.precond     = precond_q;
    high_ctrl.force_clear = fc_high_q;
    low_ctrl.step         = advance;
    low_ctrl.clear        = clear_q;
    low_ctrl.detect_mode  = is_low;
    low_ctrl.precond      = precond_q;
    low_ctrl.force_clear  = fc_low_q;
  end

  vwfd_side u_high_side (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (high_ctrl),
    .detect_ticks_i  (detect_ticks_q),
    .recover_ticks_i (recover_ticks_q),
    .fault_o         (high_fault_cur),
    .fault_next_o    (high_fault_next)
  );

  vwfd_side u_low_side (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (low_ctrl),
    .detect_ticks_i  (detect_ticks_q),
    .recover_ticks_i (recover_ticks_q),
    .fault_o         (low_fault_cur),
    .fault_next_o    (low_fault_next)
  );

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      high_fault_q <= high_fault_next;
      low_fault_q  <= low_fault_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign high_fault_o = high_fault_q;
  assign low_fault_o  = low_fault_q;

endmodule

// ----- design/vwfd_checker.sv -----
// Port-level checker for the voltage window fault debouncer, with its bind.
// Depends only on the top level's ports.
module vwfd_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    clear_all_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic                    high_fault_o,
  input logic                    low_fault_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // The input side only stalls behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result side is free");

  // A fresh result follows an item accepted through the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching item");

  // A clear item reports both faults cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && clear_all_i) ##1 !out_stall_i
    |=> out_valid_o && !high_fault_o && !low_fault_o)
    else $error("clear item did not report cleared faults");

endmodule

bind voltage_window_fault_debouncer_top vwfd_checker u_vwfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .clear_all_i  (clear_all_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .high_fault_o (high_fault_o),
  .low_fault_o  (low_fault_o)
);
